@@ rtl/core/partition_count_mod_prime_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Partition count unit assertion macros
// Concurrent assertion shorthands clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PARTITION_COUNT_MOD_PRIME_UNIT_MACROS_SVH
`define PARTITION_COUNT_MOD_PRIME_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define PCMP_ASSERT_SAME(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (cons)) \
      else $error(msg);
`define PCMP_ASSERT_NEXT(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (cons)) \
      else $error(msg);
`else
`define PCMP_ASSERT_SAME(lbl, ant, cons, msg)
`define PCMP_ASSERT_NEXT(lbl, ant, cons, msg)
`endif

`endif

@@ rtl/core/pcmp_pkg.sv @@
// ----------------------------------------------------------------------------
// Partition count package
// Field widths, sequencer states and modular arithmetic helpers.
// ----------------------------------------------------------------------------
package pcmp_pkg;

   localparam int INDEX_W = 12;
   localparam int COUNT_W = 31;

   localparam logic [COUNT_W-1:0] MODULUS_RESET = 31'h7FFF_FFFF;
   localparam logic [COUNT_W-1:0] MODULUS_MIN   = 31'd2;
   localparam logic [COUNT_W-1:0] COUNT_ZERO    = 31'd0;
   localparam logic [COUNT_W-1:0] COUNT_ONE     = 31'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GEN,
      ST_WB
   } state_type;

   function automatic logic [COUNT_W-1:0] mod_add(
      input logic [COUNT_W-1:0] a,
      input logic [COUNT_W-1:0] b,
      input logic [COUNT_W-1:0] m
   );
      logic [COUNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[COUNT_W-1:0];
   endfunction

   function automatic logic [COUNT_W-1:0] mod_sub(
      input logic [COUNT_W-1:0] a,
      input logic [COUNT_W-1:0] b,
      input logic [COUNT_W-1:0] m
   );
      logic [COUNT_W:0] s;
      s = {1'b0, a} + ({1'b0, m} - {1'b0, b});
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[COUNT_W-1:0];
   endfunction

endpackage

@@ rtl/core/pcmp_if.sv @@
// ----------------------------------------------------------------------------
// Partition count channel interfaces
// Valid/ready channels for index requests and count responses.
// ----------------------------------------------------------------------------
interface pcmp_req_if;
   import pcmp_pkg::*;

   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] index_n;

   modport source (output valid, output index_n, input ready);
   modport sink   (input valid, input index_n, output ready);
endinterface

interface pcmp_rsp_if;
   import pcmp_pkg::*;

   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] count_mod;

   modport source (output valid, output count_mod, input ready);
   modport sink   (input valid, input count_mod, output ready);
endinterface

@@ rtl/core/partition_count_mod_prime_unit.sv @@
// ----------------------------------------------------------------------------
// Partition count modulo a prime
// Answers p(n) mod the configured modulus using the pentagonal recurrence,
// rebuilding p(0..n-1) in a table RAM for every transaction.
//
//   Channel   Direction  Payload            Transfer
//   req_chan  in         index_n   12 bit   valid and ready high
//   rsp_chan  out        count_mod 31 bit   valid and ready high
//   csr       in         modulus   31 bit   csr_we high
//
// The table RAM has one read port and takes one recurrence term per cycle;
// n = 0 or a modulus below two skips the term loop and goes straight to the response.
// One request is in flight at a time; a new one is accepted as soon as the
// previous response has been loaded, even while that response is stalled.
// Reset clears the control state and loads the modulus reset value only; the table needs no clearing pass.
// ----------------------------------------------------------------------------
`include "partition_count_mod_prime_unit_macros.svh"

module partition_count_mod_prime_unit #(
   parameter int MAX_INDEX = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [pcmp_pkg::COUNT_W-1:0]  csr_wdata,
   pcmp_req_if.sink                      req_chan,
   pcmp_rsp_if.source                    rsp_chan
);
   import pcmp_pkg::*;

   localparam int AW = $clog2(MAX_INDEX);
   localparam int KW = $clog2(MAX_INDEX + 1);
   localparam int NW = (KW > INDEX_W) ? KW : INDEX_W;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] modulus_ff;
   logic [KW-1:0]      n_ff, n_in;
   logic [KW-1:0]      k_ff, k_in;
   logic [KW-1:0]      pos_ff, pos_in;
   logic [KW-1:0]      j_ff, j_in;
   logic               phase_ff, phase_in;
   logic [COUNT_W-1:0] acc_ff, acc_in;
   logic               rd_valid_ff, rd_valid_in;
   logic               rd_add_ff, rd_add_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_data_ff, rsp_data_in;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [COUNT_W-1:0] ram_wdata;
   logic [AW-1:0]      ram_raddr;
   logic [COUNT_W-1:0] ram_rdata;

   logic [NW-1:0]      n_ext;
   logic [KW-1:0]      n_sat;
   logic [KW:0]        step1;
   logic [KW:0]        pos_sub;
   logic               req_fire;

   pcmp_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (MAX_INDEX)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign req_fire          = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.count_mod = rsp_data_ff;

   always_comb begin
      n_ext = NW'(req_chan.index_n);
      if (n_ext > NW'(MAX_INDEX)) begin
         n_sat = KW'(MAX_INDEX);
      end else begin
         n_sat = n_ext[KW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         modulus_ff   <= MODULUS_RESET;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            modulus_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      k_ff        <= k_in;
      pos_ff      <= pos_in;
      j_ff        <= j_in;
      phase_ff    <= phase_in;
      acc_ff      <= acc_in;
      rd_add_ff   <= rd_add_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      pos_in       = pos_ff;
      j_in         = j_ff;
      phase_in     = phase_ff;
      rd_add_in    = rd_add_ff;
      rd_valid_in  = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = k_ff[AW-1:0];
      ram_wdata    = acc_ff;
      step1        = {j_ff, 1'b0} - (KW+1)'(1);
      pos_sub      = {1'b0, pos_ff} - step1;
      ram_raddr    = pos_sub[AW-1:0];

      if (rd_valid_ff) begin
         acc_in = rd_add_ff ? mod_add(acc_ff, ram_rdata, modulus_ff)
                            : mod_sub(acc_ff, ram_rdata, modulus_ff);
      end else begin
         acc_in = acc_ff;
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if ((modulus_ff < MODULUS_MIN) || (n_sat == '0)) begin
                  n_in     = '0;
                  k_in     = '0;
                  acc_in   = (modulus_ff < MODULUS_MIN) ? COUNT_ZERO : COUNT_ONE;
                  state_in = ST_WB;
               end else begin
                  n_in      = n_sat;
                  k_in      = KW'(1);
                  pos_in    = KW'(1);
                  j_in      = KW'(1);
                  phase_in  = 1'b0;
                  acc_in    = COUNT_ZERO;
                  ram_we    = 1'b1;
                  ram_waddr = '0;
                  ram_wdata = COUNT_ONE;
                  state_in  = ST_GEN;
               end
            end
         end
         ST_GEN: begin
            if (!phase_ff) begin
               if ({1'b0, pos_ff} < step1) begin
                  state_in = ST_WB;
               end else begin
                  pos_in      = pos_sub[KW-1:0];
                  rd_valid_in = 1'b1;
                  rd_add_in   = j_ff[0];
                  phase_in    = 1'b1;
               end
            end else begin
               pos_sub   = {1'b0, pos_ff} - {1'b0, j_ff};
               ram_raddr = pos_sub[AW-1:0];
               if (pos_ff < j_ff) begin
                  state_in = ST_WB;
               end else begin
                  pos_in      = pos_sub[KW-1:0];
                  rd_valid_in = 1'b1;
                  rd_add_in   = j_ff[0];
                  j_in        = j_ff + KW'(1);
                  phase_in    = 1'b0;
               end
            end
         end
         ST_WB: begin
            if (k_ff == n_ff) begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = acc_ff;
                  state_in     = ST_IDLE;
               end
            end else begin
               ram_we    = 1'b1;
               ram_waddr = k_ff[AW-1:0];
               ram_wdata = acc_ff;
               k_in      = k_ff + KW'(1);
               pos_in    = k_ff + KW'(1);
               j_in      = KW'(1);
               phase_in  = 1'b0;
               acc_in    = COUNT_ZERO;
               state_in  = ST_GEN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `PCMP_ASSERT_SAME(a_no_write_in_gen, state_ff == ST_GEN, !ram_we,
      "table written while terms are being read")
   `PCMP_ASSERT_NEXT(a_read_only_from_gen, state_ff != ST_GEN, !rd_valid_ff,
      "read data returned without a read issued in the term loop")
   `PCMP_ASSERT_SAME(a_gen_index_range, state_ff == ST_GEN,
      (k_ff != '0) && (k_ff <= n_ff), "recurrence index out of range")
   `PCMP_ASSERT_SAME(a_acc_reduced, (state_ff == ST_WB) && (k_ff != '0),
      acc_ff < modulus_ff, "partial count not reduced below the modulus")
   `PCMP_ASSERT_NEXT(a_busy_after_accept, req_fire, state_ff != ST_IDLE,
      "sequencer idle after accepting a transaction")

endmodule

@@ rtl/core/pcmp_ram.sv @@
// ----------------------------------------------------------------------------
// Partition count generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module pcmp_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
